// File: hw/rtl/joystick_frame_axis_calibrator_macros.svh
// assertion macros for the joystick frame axis calibrator
// no dependencies; the synthesis build defines SYNTH to drop the checks
`ifndef JOYSTICK_FRAME_AXIS_CALIBRATOR_MACROS_SVH
`define JOYSTICK_FRAME_AXIS_CALIBRATOR_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define JFAC_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("jfac assertion failed");

// next-cycle implication
`define JFAC_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("jfac assertion failed");

`else

`define JFAC_ASSERT_IMP(label, clk, rst, pre, post)
`define JFAC_ASSERT_NXT(label, clk, rst, pre, post)

`endif

`endif

// File: hw/rtl/jfac_pkg.sv
// shared types and constants for the joystick frame axis calibrator
// no dependencies
`timescale 1ns / 1ps

package jfac_pkg;

  // frame markers
  localparam logic [7:0] START_BYTE = 8'd255;
  localparam logic [7:0] STOP_BYTE  = 8'd254;

  // scaling constants
  localparam int unsigned NUM_W      = 15;           // |d| * 126 fits here
  localparam int unsigned DIV_STEPS  = NUM_W;        // one quotient bit per cycle
  localparam logic [NUM_W-1:0] MAX_SCALED = 15'd32130;
  localparam logic signed [15:0] SAT_HI = 16'sd127;
  localparam logic signed [15:0] SAT_LO = -16'sd128;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_X_MIN     = 3'd0,
    REG_X_ZERO    = 3'd1,
    REG_X_MAX     = 3'd2,
    REG_Y_MIN     = 3'd3,
    REG_Y_ZERO    = 3'd4,
    REG_Y_MAX     = 3'd5,
    REG_DEAD_ZONE = 3'd6
  } reg_index_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DIV,
    ST_FIX,
    ST_APPLY,
    ST_LOAD
  } state_t;

endpackage

// File: hw/rtl/joystick_frame_axis_calibrator.sv
// joystick frame axis calibrator: frame detect, axis scaling, dead zone, hold
// depends on jfac_pkg and joystick_frame_axis_calibrator_macros.svh
`timescale 1ns / 1ps
`include "joystick_frame_axis_calibrator_macros.svh"

// Serial bytes enter one per request and slide through a five byte window.
// A STOP byte arriving while the oldest window byte is START completes a frame;
// the X and Y bytes are then scaled one after the other by a single shared
// restoring divider that makes one quotient bit per cycle. A byte that does not
// complete a frame does not stall the input. A completing byte keeps the input
// stalled while both axes run (per axis: setup, 15 divide steps, dead-zone fix
// and update), then through a load step that lasts while the previous result
// still waits on the output side. Held values and update flags come out as one
// result request per frame.
module joystick_frame_axis_calibrator import jfac_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  // configuration write port
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [14:0]       cfg_data,
  // byte input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        rx_byte,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic signed [7:0] axis_x,
  output logic signed [7:0] axis_y,
  output logic              x_updated,
  output logic              y_updated
);

  // calibration registers
  logic [7:0]  x_min, x_zero, x_max, y_min, y_zero, y_max;
  logic [14:0] dead_zone;

  // frame window and per-axis state
  logic [7:0]         byte_window [5];
  logic signed [15:0] prev_axis [2];
  logic signed [7:0]  held_axis [2];
  logic [1:0]         upd_flag;

  // sequencer and divider datapath
  state_t             state, state_next;
  logic               axis;       // 0 = X, 1 = Y
  logic [3:0]         cnt;
  logic [NUM_W-1:0]   num;        // dividend, becomes quotient
  logic [7:0]         rem;
  logic [7:0]         den;
  logic               neg;
  logic               ok;
  logic signed [15:0] val;

  logic in_fire, frame_hit, out_free;

  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign frame_hit = (byte_window[0] == START_BYTE) && (rx_byte == STOP_BYTE);
  assign out_free  = !out_valid || !out_stall;

  // configuration writes, out-of-range indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      x_min     <= 8'd0;
      x_zero    <= 8'd128;
      x_max     <= 8'd255;
      y_min     <= 8'd0;
      y_zero    <= 8'd128;
      y_max     <= 8'd255;
      dead_zone <= 15'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_X_MIN:     x_min     <= cfg_data[7:0];
        REG_X_ZERO:    x_zero    <= cfg_data[7:0];
        REG_X_MAX:     x_max     <= cfg_data[7:0];
        REG_Y_MIN:     y_min     <= cfg_data[7:0];
        REG_Y_ZERO:    y_zero    <= cfg_data[7:0];
        REG_Y_MAX:     y_max     <= cfg_data[7:0];
        REG_DEAD_ZONE: dead_zone <= cfg_data;
        default: ;
      endcase
    end
  end

  // sliding byte window
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) byte_window[i] <= 8'd0;
    end else if (in_fire) begin
      for (int i = 0; i < 4; i++) byte_window[i] <= byte_window[i+1];
      byte_window[4] <= rx_byte;
    end
  end

  // setup terms; after the shift X sits in slot 2 and Y in slot 3
  logic [7:0]        raw, lo, mid, hi;
  logic signed [8:0] d, span_pos, span_neg;
  logic [7:0]        abs_d;
  logic [NUM_W-1:0]  num_init;

  always_comb begin
    raw = axis ? byte_window[3] : byte_window[2];
    lo  = axis ? y_min  : x_min;
    mid = axis ? y_zero : x_zero;
    hi  = axis ? y_max  : x_max;
    d        = $signed({1'b0, raw}) - $signed({1'b0, mid});
    span_pos = $signed({1'b0, hi})  - $signed({1'b0, mid});
    span_neg = $signed({1'b0, mid}) - $signed({1'b0, lo});
    abs_d    = d[8] ? 8'(-d) : d[7:0];
    // |d| * 126 as a shift and subtract
    num_init = {abs_d, 7'd0} - {6'd0, abs_d, 1'b0};
  end

  // one restoring divide step
  logic [8:0] trial;
  logic       fits;
  assign trial = {rem, num[NUM_W-1]};
  assign fits  = (trial >= {1'b0, den});

  // dead zone on the magnitude
  logic [NUM_W-1:0] mag;
  always_comb begin
    mag = ok ? num : '0;
    if ((mag != '0) && (mag < dead_zone)) mag = '0;
  end

  // change test against the previous frame
  logic signed [16:0] diff;
  logic [16:0]        abs_diff;
  logic               upd;
  assign diff     = {val[15], val} - {prev_axis[axis][15], prev_axis[axis]};
  assign abs_diff = diff[16] ? 17'(-diff) : diff;
  assign upd      = (val != prev_axis[axis]) && (abs_diff >= {2'd0, dead_zone});

  function automatic logic signed [7:0] sat8(input logic signed [15:0] v);
    if (v > SAT_HI) return 8'sd127;
    if (v < SAT_LO) return -8'sd128;
    return v[7:0];
  endfunction

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_fire && frame_hit) state_next = ST_SETUP;
      ST_SETUP: state_next = ST_DIV;
      ST_DIV:   if (cnt == 4'(DIV_STEPS - 1)) state_next = ST_FIX;
      ST_FIX:   state_next = ST_APPLY;
      ST_APPLY: state_next = axis ? ST_LOAD : ST_SETUP;
      ST_LOAD:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer control and axis state
  always_ff @(posedge clk) begin
    if (rst) begin
      axis         <= 1'b0;
      cnt          <= 4'd0;
      prev_axis[0] <= 16'sd0;
      prev_axis[1] <= 16'sd0;
      held_axis[0] <= 8'sd0;
      held_axis[1] <= 8'sd0;
      upd_flag     <= 2'b00;
    end else begin
      unique case (state)
        ST_IDLE:  axis <= 1'b0;
        ST_SETUP: cnt  <= 4'd0;
        ST_DIV:   cnt  <= cnt + 4'd1;
        ST_APPLY: begin
          prev_axis[axis] <= val;
          upd_flag[axis]  <= upd;
          if (upd) held_axis[axis] <= sat8(val);
          axis <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // divider datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_SETUP: begin
        rem <= 8'd0;
        num <= num_init;
        neg <= d[8];
        if (!d[8] && (d != 9'sd0) && (span_pos > 9'sd0)) begin
          ok  <= 1'b1;
          den <= span_pos[7:0];
        end else if (d[8] && (span_neg > 9'sd0)) begin
          ok  <= 1'b1;
          den <= span_neg[7:0];
        end else begin
          ok  <= 1'b0;
          den <= 8'd1;
        end
      end
      ST_DIV: begin
        rem <= fits ? 8'(trial - {1'b0, den}) : trial[7:0];
        num <= {num[NUM_W-2:0], fits};
      end
      ST_FIX: val <= neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_LOAD && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD && out_free) begin
      axis_x    <= held_axis[0];
      axis_y    <= held_axis[1];
      x_updated <= upd_flag[0];
      y_updated <= upd_flag[1];
    end
  end

  // a completed frame starts the X axis
  `JFAC_ASSERT_NXT(a_frame_starts_x, clk, rst, in_fire && frame_hit, state == ST_SETUP && !axis)
  // a new result only comes from the load step
  `JFAC_ASSERT_IMP(a_result_from_load, clk, rst, $rose(out_valid), $past(state) == ST_LOAD)
  // quotient never exceeds the largest scaled value
  `JFAC_ASSERT_IMP(a_quot_range, clk, rst, state == ST_FIX && ok, num <= MAX_SCALED)
  // the divider runs its full step count before the fix step
  `JFAC_ASSERT_IMP(a_div_len, clk, rst, state == ST_FIX, cnt == 4'(DIV_STEPS))

endmodule
